[design/biq_pkg.sv]
// Shared types and constants of the biquad filter.
package biq_pkg;

	localparam int COEF_WIDTH     = 16;
	localparam int COEF_FRAC_BITS = 14;
	localparam int ACC_WIDTH      = 36;
	localparam int NUM_COEFS      = 5;
	localparam int CFG_IDX_WIDTH  = 3;

	typedef logic signed [COEF_WIDTH-1:0] coef_t;
	typedef coef_t coef_bank_t [NUM_COEFS];

	localparam logic [CFG_IDX_WIDTH-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_A2 = 3'd4;

	localparam coef_bank_t COEF_RESET = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0};

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_ACC,
		OP_SAT,
		OP_FB1,
		OP_FB2,
		OP_FIN
	} biq_op_t;

	typedef struct packed {
		biq_op_t op;
		logic    clr;
	} biq_ctrl_t;

endpackage

[design/biq_mac.sv]
// Shared multiply-accumulate unit with the delay accumulators and the output register.
module biq_mac import biq_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  biq_ctrl_t                      ctrl,
	input  coef_bank_t                     coefs,
	input  logic signed [SAMPLE_WIDTH-1:0] x_in,
	output logic signed [SAMPLE_WIDTH-1:0] y_out
);

	localparam int PW = COEF_WIDTH + SAMPLE_WIDTH;
	localparam int MW = ((PW > ACC_WIDTH) ? PW : ACC_WIDTH) + 1;
	localparam logic signed [MW-1:0] RND = MW'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam int HI_LSB = COEF_FRAC_BITS + SAMPLE_WIDTH - 1;

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic signed [SAMPLE_WIDTH-1:0] y_out_q;
	logic signed [PW-1:0]           prod_q;
	logic signed [MW-1:0]           acc_q;
	logic signed [ACC_WIDTH-1:0]    d1_q;
	logic signed [ACC_WIDTH-1:0]    d2_q;

	coef_t                          mul_c;
	logic signed [SAMPLE_WIDTH-1:0] mul_m;
	logic signed [PW-1:0]           mul_c_ext;
	logic signed [PW-1:0]           mul_m_ext;
	logic signed [PW-1:0]           mul_p;
	logic signed [MW-1:0]           add_a;
	logic signed [MW-1:0]           add_b;
	logic                           add_sub;
	logic                           add_rnd;
	logic signed [MW-1:0]           sum;
	logic [MW-HI_LSB-1:0]           acc_hi;
	logic                           ovf;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;

	always_comb begin
		mul_c   = '0;
		mul_m   = '0;
		add_a   = '0;
		add_sub = 1'b0;
		add_rnd = 1'b0;
		unique case (ctrl.op)
			OP_LOAD: begin
				mul_c = coefs[REG_B0];
				mul_m = x_in;
			end
			OP_ACC: begin
				mul_c   = coefs[REG_B1];
				mul_m   = x_q;
				add_a   = MW'(d1_q);
				add_rnd = 1'b1;
			end
			OP_SAT: begin
				mul_c = coefs[REG_B2];
				mul_m = x_q;
				add_a = MW'(d2_q);
			end
			OP_FB1: begin
				mul_c = coefs[REG_A1];
				mul_m = y_q;
			end
			OP_FB2: begin
				mul_c   = coefs[REG_A2];
				mul_m   = y_q;
				add_a   = MW'(d1_q);
				add_sub = 1'b1;
			end
			OP_FIN: begin
				add_a   = MW'(d2_q);
				add_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign mul_c_ext = PW'(mul_c);
	assign mul_m_ext = PW'(mul_m);
	assign mul_p     = mul_c_ext * mul_m_ext;

	assign add_b = add_sub ? ~MW'(prod_q) : MW'(prod_q);
	assign sum   = add_a + add_b + MW'(add_sub) + (add_rnd ? RND : MW'(0));

	assign acc_hi = acc_q[MW-1:HI_LSB];
	assign ovf    = !((&acc_hi) || (~|acc_hi));
	assign y_sat  = ovf ? (acc_q[MW-1] ? Y_MIN : Y_MAX)
	                    : acc_q[HI_LSB:COEF_FRAC_BITS];

	always_ff @(posedge clk) begin
		if (ctrl.op != OP_NONE && ctrl.op != OP_FIN) begin
			prod_q <= mul_p;
		end
		if (ctrl.op == OP_LOAD) begin
			x_q <= x_in;
		end
		if (ctrl.op == OP_ACC) begin
			acc_q <= sum;
		end
		if (ctrl.op == OP_SAT) begin
			y_q <= y_sat;
		end
		if (ctrl.op == OP_FIN) begin
			y_out_q <= y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (ctrl.clr) begin
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			if (ctrl.op == OP_SAT || ctrl.op == OP_FB2) begin
				d1_q <= sum[ACC_WIDTH-1:0];
			end
			if (ctrl.op == OP_FB1 || ctrl.op == OP_FIN) begin
				d2_q <= sum[ACC_WIDTH-1:0];
			end
		end
	end

	assign y_out = y_out_q;

endmodule

[design/biq_ctrl.sv]
// Sequencer of the biquad filter: handshakes and step order of the shared unit.
module biq_ctrl import biq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  logic      cfg_clr,
	output biq_ctrl_t ctrl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_SAT,
		ST_FB1,
		ST_FB2,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_xfer;
	logic   out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_xfer) state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_SAT;
				ST_SAT:  state_q <= ST_FB1;
				ST_FB1:  state_q <= ST_FB2;
				ST_FB2:  state_q <= ST_FIN;
				ST_FIN:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		ctrl.clr = cfg_clr;
		ctrl.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: ctrl.op = in_xfer ? OP_LOAD : OP_NONE;
			ST_ACC:  ctrl.op = OP_ACC;
			ST_SAT:  ctrl.op = OP_SAT;
			ST_FB1:  ctrl.op = OP_FB1;
			ST_FB2:  ctrl.op = OP_FB2;
			ST_FIN:  ctrl.op = out_load ? OP_FIN : OP_NONE;
			default: ctrl.op = OP_NONE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[design/biquad_iir_filter_top.sv]
// Top level of the biquad IIR filter in transposed direct form II.
//
// Input channel: sample_in with in_valid / in_stall; a transfer takes place at
// a rising edge with in_valid high and in_stall low. Output channel: sample_out
// with out_valid / out_stall, same rule. Coefficients b0, b1, b2, a1, a2
// (signed Q2.14) are written through cfg_wr_en / cfg_index / cfg_data at
// indexes 0 to 4; any such write also clears both delay accumulators.
//
// One item takes the transfer cycle followed by five steps of the single
// shared multiplier and adder (five products and their sums). in_stall is
// high for those five steps. The result is registered; a new sample is
// taken while it waits. out_valid rises once the last step has loaded the
// output register.
// If the receiver still stalls when the next result is ready, the sequencer
// holds in its last step until the output register frees up.
//
// Reset: coefficients return to b0 = 1.0 and the rest to zero, the delay
// accumulators clear and no result is pending.
module biquad_iir_filter_top import biq_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  logic                           cfg_wr_en,
	input  logic [CFG_IDX_WIDTH-1:0]       cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_data
);

	coef_bank_t coef_q;
	logic       cfg_hit;
	biq_ctrl_t  ctrl;

	always_comb begin
		unique case (cfg_index) inside
			REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: cfg_hit = cfg_wr_en;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg_hit) begin
			coef_q[cfg_index] <= coef_t'(cfg_data);
		end
	end

	biq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_clr   (cfg_hit),
		.ctrl      (ctrl)
	);

	biq_mac #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.coefs  (coef_q),
		.x_in   (sample_in),
		.y_out  (sample_out)
	);

endmodule

[design/biq_checker.sv]
// Port-level checks of the biquad filter and their binding to the top level.
module biq_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input logic                           cfg_wr_en
);

	logic in_xfer;

	assign in_xfer = in_valid && !in_stall;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
		else $error("input taken during a running item");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_xfer, 6))
		else $error("result appeared without a matching input transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("stalled result changed or dropped");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(sample_in))
		else $error("stalled input changed or dropped");

	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |-> !in_stall && !out_valid)
		else $error("coefficient write while an item is in flight");

endmodule

bind biquad_iir_filter_top biq_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_biq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.sample_in  (sample_in),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out),
	.cfg_wr_en  (cfg_wr_en)
);
